// File: rtl/core/bole_pkg.sv
// Shared types and constants for the bounded ordered list engine.
// No dependencies; used by bole_cell and bounded_ordered_list_engine_core.
package bole_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int ENTRY_W      = 32;
    localparam int FUNC_W       = 3;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 7;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT  = 3'd0,
        FN_PUSH_MIDDLE = 3'd1,
        FN_PUSH_BACK   = 3'd2,
        FN_POP_FRONT   = 3'd3,
        FN_POP_MIDDLE  = 3'd4,
        FN_POP_BACK    = 3'd5,
        FN_SEARCH      = 3'd6
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic upd;     // request accepted this cycle
        logic ins;     // open a gap at pos
        logic rem;     // close the gap at pos
        logic chk;     // search request
    } cell_ctrl_t;

endpackage

// File: rtl/core/bounded_ordered_list_engine_core.sv
// Bounded ordered list engine: a chain of CAPACITY cells shifted in place.
// The cells update when a request is accepted; the front/back/found result is then
// formed from the updated chain and registered with out_valid. A new request is stalled
// while that result is being formed, and while out_valid is held by out_stall.
// Reset (async, rst_n low) empties the list and clears both handshakes.
// Depends on bole_pkg and bole_cell.
module bounded_ordered_list_engine_core #(
    parameter int CAPACITY = bole_pkg::DEF_CAPACITY
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [bole_pkg::FUNC_W-1:0]          func,
    input  logic signed [bole_pkg::ENTRY_W-1:0]  entry_value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [bole_pkg::STATUS_W-1:0]        status,
    output logic                                 found,
    output logic [bole_pkg::OCC_W-1:0]           occupancy,
    output logic signed [bole_pkg::ENTRY_W-1:0]  front_value,
    output logic signed [bole_pkg::ENTRY_W-1:0]  back_value
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic signed [bole_pkg::ENTRY_W-1:0] cell_value [CAPACITY];
    logic signed [bole_pkg::ENTRY_W-1:0] cell_tail  [CAPACITY];
    logic [CAPACITY-1:0]                 cell_match;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    pend_reg;
    bole_pkg::status_t       st_hold_reg;
    logic                    out_valid_reg;
    bole_pkg::status_t       status_reg;
    logic                    found_reg;
    logic [bole_pkg::OCC_W-1:0]          occ_reg;
    logic signed [bole_pkg::ENTRY_W-1:0] front_reg;
    logic signed [bole_pkg::ENTRY_W-1:0] back_reg;

    logic                    accept;
    logic                    is_push, is_pop, is_search;
    bole_pkg::status_t       st;
    logic [CNT_W-1:0]        pos;
    bole_pkg::cell_ctrl_t    ctrl;
    logic signed [bole_pkg::ENTRY_W-1:0] back_any;

    assign in_stall = pend_reg | (out_valid_reg & out_stall);
    assign accept   = in_valid & ~in_stall;

    // command decode
    always_comb
    begin
        is_push   = 1'b0;
        is_pop    = 1'b0;
        is_search = 1'b0;
        pos       = '0;
        unique case (bole_pkg::func_t'(func)) inside
            bole_pkg::FN_PUSH_FRONT: is_push = 1'b1;
            bole_pkg::FN_PUSH_MIDDLE:
            begin
                is_push = 1'b1;
                pos     = (count_reg == '0) ? '0 : (count_reg >> 1) + CNT_W'(1);
            end
            bole_pkg::FN_PUSH_BACK:
            begin
                is_push = 1'b1;
                pos     = count_reg;
            end
            bole_pkg::FN_POP_FRONT: is_pop = 1'b1;
            bole_pkg::FN_POP_MIDDLE:
            begin
                is_pop = 1'b1;
                pos    = count_reg >> 1;
            end
            bole_pkg::FN_POP_BACK:
            begin
                is_pop = 1'b1;
                pos    = count_reg - CNT_W'(1);
            end
            bole_pkg::FN_SEARCH: is_search = 1'b1;
            default: ;
        endcase
    end

    always_comb
    begin
        st = bole_pkg::ST_DONE;
        if (is_push && (count_reg == CAP_CNT))
            st = bole_pkg::ST_FULL;
        else if (is_pop && (count_reg == '0))
            st = bole_pkg::ST_EMPTY;
    end

    always_comb
    begin
        ctrl.upd = accept;
        ctrl.ins = accept && is_push && (st == bole_pkg::ST_DONE);
        ctrl.rem = accept && is_pop && (st == bole_pkg::ST_DONE);
        ctrl.chk = is_search;
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.rem)
            count_next = count_reg - CNT_W'(1);
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [bole_pkg::ENTRY_W-1:0] left_v;
            logic signed [bole_pkg::ENTRY_W-1:0] right_v;
            if (gi == 0)
            begin : g_first
                assign left_v = '0;
            end
            else
            begin : g_mid_l
                assign left_v = cell_value[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_v = cell_value[gi];
            end
            else
            begin : g_mid_r
                assign right_v = cell_value[gi+1];
            end

            bole_cell #(
                .CAPACITY (CAPACITY),
                .IDX      (gi),
                .CNT_W    (CNT_W)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .pos         (pos),
                .count       (count_reg),
                .new_value   (entry_value),
                .left_value  (left_v),
                .right_value (right_v),
                .value       (cell_value[gi]),
                .tail_value  (cell_tail[gi]),
                .match       (cell_match[gi])
            );
        end
    endgenerate

    // at most one cell flags itself as the tail
    always_comb
    begin
        back_any = '0;
        for (int i = 0; i < CAPACITY; i++)
            back_any = back_any | cell_tail[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= accept;
            if (pend_reg)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            st_hold_reg <= st;
        if (pend_reg)
        begin
            status_reg <= st_hold_reg;
            found_reg  <= |cell_match;
            occ_reg    <= bole_pkg::OCC_W'(count_reg);
            front_reg  <= (count_reg == '0) ? '0 : cell_value[0];
            back_reg   <= back_any;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign occupancy   = occ_reg;
    assign front_value = front_reg;
    assign back_value  = back_reg;

endmodule

// File: rtl/core/bole_cell.sv
// One storage cell of the list chain: holds one entry, shifts with its neighbours.
// Depends on bole_pkg.
module bole_cell #(
    parameter int CAPACITY = bole_pkg::DEF_CAPACITY,
    parameter int IDX      = 0,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                                clk,
    input  bole_pkg::cell_ctrl_t                ctrl,
    input  logic [CNT_W-1:0]                    pos,
    input  logic [CNT_W-1:0]                    count,
    input  logic signed [bole_pkg::ENTRY_W-1:0] new_value,
    input  logic signed [bole_pkg::ENTRY_W-1:0] left_value,
    input  logic signed [bole_pkg::ENTRY_W-1:0] right_value,
    output logic signed [bole_pkg::ENTRY_W-1:0] value,
    output logic signed [bole_pkg::ENTRY_W-1:0] tail_value,
    output logic                                match
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic signed [bole_pkg::ENTRY_W-1:0] value_reg;
    logic signed [bole_pkg::ENTRY_W-1:0] value_next;
    logic                                match_reg;
    logic                                match_next;
    logic                                is_last;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            if (MY_IDX > pos)
                value_next = left_value;
            else if (MY_IDX == pos)
                value_next = new_value;
        end
        else if (ctrl.rem)
        begin
            if (MY_IDX >= pos)
                value_next = right_value;
        end
    end

    assign match_next = ctrl.chk && (MY_IDX < count) && (value_reg == new_value);

    always_ff @(posedge clk)
    begin
        if (ctrl.upd)
        begin
            value_reg <= value_next;
            match_reg <= match_next;
        end
    end

    // count - 1 wraps to all ones when empty, which no cell index reaches
    assign is_last    = (MY_IDX == count - CNT_W'(1));
    assign value      = value_reg;
    assign tail_value = is_last ? value_reg : '0;
    assign match      = match_reg;

endmodule
